### rtl/core/sd_spi_host_sequencer_defines.svh
// Assertion macros used by the sequencer.
`ifndef SD_SPI_HOST_SEQUENCER_DEFINES_SVH
`define SD_SPI_HOST_SEQUENCER_DEFINES_SVH
`define SDS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SDS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/core/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// Types and constants of the SD card SPI host sequencer.
// ----------------------------------------------------------------------------
package sds_pkg;
  localparam int BlockBytes = 512;
  localparam int CountBits = 16;
  localparam int DummyBytes = 80;

  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_XFER = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_RESET_FAIL = 3'd1;
  localparam logic [2:0] ST_UNUSABLE = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_TOKEN = 3'd4;

  localparam logic [7:0] TOK_START = 8'hFE;
  localparam logic [7:0] TOK_MULTI = 8'hFC;
  localparam logic [7:0] TOK_STOP = 8'hFD;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] sector_address;
    logic [15:0] block_count;
    logic [7:0]  card_byte;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]  send_byte;
    logic        send_valid;
    logic        chip_select;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        want_write_byte;
    logic        finished;
    logic [2:0]  status;
    logic [15:0] blocks_done;
    logic [3:0]  card_kind;
    logic        busy_res;
  } res_t;
endpackage

### rtl/core/sds_if.sv
// ----------------------------------------------------------------------------
// sds_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface sds_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sd_spi_host_sequencer.sv
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer
// SD card host in SPI mode: one result per accepted request.
// ----------------------------------------------------------------------------
// channel  dir  payload
// req      in   operation, sector_address, block_count, card_byte, write_byte
// res      out  send_byte ... busy_res
// One transaction is taken per cycle while the result register is empty or taken.
// A result register holds the answer; req is ready while it is empty or taken.
// Synchronous reset returns the sequencer to idle with cleared state.
// A stalled result stalls only the request side.
module sd_spi_host_sequencer #(
  parameter int COUNT_BITS = sds_pkg::CountBits
) (
  input logic clk,
  input logic rst,
  sds_if.sink   req,
  sds_if.source res
);
  import sds_pkg::*;
  `include "sd_spi_host_sequencer_defines.svh"

  localparam logic [5:0] PH_IDLE = 6'd0, PH_C0 = 6'd1, PH_C8 = 6'd2, PH_A41V2 = 6'd3,
    PH_C58 = 6'd4, PH_A41V1 = 6'd5, PH_LOOP = 6'd6, PH_C16 = 6'd7, PH_C17 = 6'd8,
    PH_C18 = 6'd9, PH_C12 = 6'd10, PH_C24 = 6'd11, PH_A23 = 6'd12, PH_C25 = 6'd13,
    PH_DUMMY = 6'd14, PH_R7 = 6'd15, PH_OCR = 6'd16, PH_RTOK = 6'd17, PH_RDAT = 6'd18,
    PH_RCRC = 6'd19, PH_WPOLL = 6'd20, PH_WDAT = 6'd21, PH_WCRC = 6'd22,
    PH_WSTAT = 6'd23, PH_SPOLL = 6'd24, PH_SSENT = 6'd25;
  localparam logic [9:0] LastByte = 10'(BlockBytes - 1);

  logic [5:0]  phase, phase_next;
  logic [9:0]  byte_counter, byte_counter_next;
  logic [47:0] command_frame, command_frame_next;
  logic [2:0]  frame_position, frame_position_next;
  logic [3:0]  card_type_bits, card_type_bits_next;
  logic [COUNT_BITS-1:0] blocks_remaining, blocks_remaining_next;
  logic [COUNT_BITS-1:0] blocks_counted, blocks_counted_next;
  logic [31:0] card_address, card_address_next;
  logic [6:0]  app_command_pending, app_command_pending_next;
  logic [31:0] ocr_word, ocr_word_next;
  logic [2:0]  request_status, request_status_next;
  res_t        out_reg, out_next;
  logic        out_valid;
  logic        take;
  req_t        d;
  logic [COUNT_BITS-1:0] cnt;

  assign req.ready = !out_valid || res.ready;
  assign take = req.valid && req.ready;
  assign res.valid = out_valid;
  assign res.data = out_reg;
  assign d = req.data;
  assign cnt = COUNT_BITS'(d.block_count);

  function automatic logic [47:0] build_frame(input logic [5:0] idx, input logic [31:0] arg);
    logic [7:0] crc;
    crc = (idx == 6'd0) ? 8'h95 : ((idx == 6'd8) ? 8'h87 : 8'h01);
    return {2'b01, idx, arg, crc};
  endfunction

  // Command index, argument and ACMD flag for a command phase.
  function automatic logic [38:0] cmd_of(input logic [5:0] ph, input logic [3:0] ctb,
                                         input logic [31:0] addr,
                                         input logic [COUNT_BITS-1:0] rem);
    logic [5:0] idx;
    logic [31:0] arg;
    logic acmd;
    idx = 6'd25; arg = addr; acmd = 1'b0;
    case (ph)
      PH_C0: begin idx = 6'd0; arg = '0; end
      PH_C8: begin idx = 6'd8; arg = 32'h1AA; end
      PH_A41V2: begin idx = 6'd41; arg = 32'h4000_0000; acmd = 1'b1; end
      PH_C58: begin idx = 6'd58; arg = '0; end
      PH_A41V1: begin idx = 6'd41; arg = '0; acmd = 1'b1; end
      PH_LOOP: begin
        arg = '0;
        if (ctb[0]) idx = 6'd1; else begin idx = 6'd41; acmd = 1'b1; end
      end
      PH_C16: begin idx = 6'd16; arg = 32'(BlockBytes); end
      PH_C17: idx = 6'd17;
      PH_C18: idx = 6'd18;
      PH_C12: begin idx = 6'd12; arg = '0; end
      PH_C24: idx = 6'd24;
      PH_A23: begin idx = 6'd23; arg = 32'(rem); acmd = 1'b1; end
      default: idx = 6'd25;
    endcase
    return {acmd, idx, arg};
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [5:0] iss;
    logic do_issue;
    logic [38:0] ci;
    logic [5:0] fcmd;
    logic [7:0] resp;
    logic do_resp;
    logic do_fin;
    logic [2:0] fin_st;
    logic [31:0] ocr_sh;
    phase_next = phase;
    byte_counter_next = byte_counter;
    command_frame_next = command_frame;
    frame_position_next = frame_position;
    card_type_bits_next = card_type_bits;
    blocks_remaining_next = blocks_remaining;
    blocks_counted_next = blocks_counted;
    card_address_next = card_address;
    app_command_pending_next = app_command_pending;
    ocr_word_next = ocr_word;
    request_status_next = request_status;
    out_next = '0;
    b = d.card_byte;
    iss = PH_IDLE;
    do_issue = 1'b0;
    do_resp = 1'b0;
    resp = b;
    do_fin = 1'b0;
    fin_st = ST_OK;
    fcmd = command_frame[45:40];
    ocr_sh = {ocr_word[23:0], b};
    ci = '0;

    if (d.operation != OP_XFER) begin
      if (phase == PH_IDLE) begin
        request_status_next = ST_OK;
        blocks_counted_next = '0;
        if (d.operation == OP_INIT) begin
          card_type_bits_next = '0;
          blocks_remaining_next = '0;
          phase_next = PH_DUMMY;
          byte_counter_next = 10'd1;
          out_next.send_byte = IDLE_BYTE;
          out_next.send_valid = 1'b1;
        end else begin
          blocks_remaining_next = cnt;
          card_address_next = card_type_bits[3] ? d.sector_address
                                                : {d.sector_address[22:0], 9'd0};
          if (cnt == '0) begin
            do_fin = 1'b1;
          end else begin
            do_issue = 1'b1;
            if (d.operation == OP_READ) iss = (cnt == 1) ? PH_C17 : PH_C18;
            else if (cnt == 1) iss = PH_C24;
            else iss = (card_type_bits[2:1] != 2'b00) ? PH_A23 : PH_C25;
          end
        end
      end
    end else if (phase != PH_IDLE) begin
      if (phase <= PH_C25) begin
        if (frame_position < 3'd5) begin
          frame_position_next = frame_position + 3'd1;
          out_next.send_valid = 1'b1;
          case (frame_position)
            3'd0: out_next.send_byte = command_frame[39:32];
            3'd1: out_next.send_byte = command_frame[31:24];
            3'd2: out_next.send_byte = command_frame[23:16];
            3'd3: out_next.send_byte = command_frame[15:8];
            default: out_next.send_byte = command_frame[7:0];
          endcase
        end else if (frame_position == 3'd5) begin
          frame_position_next = 3'd6;
          out_next.send_byte = IDLE_BYTE;
          out_next.send_valid = 1'b1;
        end else if (b[7]) begin
          out_next.send_byte = IDLE_BYTE;
          out_next.send_valid = 1'b1;
        end else if (app_command_pending != '0) begin
          app_command_pending_next = '0;
          if (b > 8'd1) begin
            do_resp = 1'b1;
          end else begin
            ci = cmd_of(phase, card_type_bits, card_address, blocks_remaining);
            command_frame_next = build_frame(ci[37:32], ci[31:0]);
            frame_position_next = '0;
            out_next.send_byte = command_frame_next[47:40];
            out_next.send_valid = 1'b1;
          end
        end else begin
          do_resp = 1'b1;
        end
        if (do_resp) begin
          case (phase)
            PH_C0: if (resp != 8'd1) begin do_fin = 1'b1; fin_st = ST_RESET_FAIL; end
                   else begin do_issue = 1'b1; iss = PH_C8; end
            PH_C8: if (resp == 8'd1) begin
                     phase_next = PH_R7; byte_counter_next = '0; ocr_word_next = '0;
                     out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
                   end else begin do_issue = 1'b1; iss = PH_A41V1; end
            PH_A41V2: begin do_issue = 1'b1; iss = (resp != 0) ? PH_A41V2 : PH_C58; end
            PH_C58: if (resp == 8'd0) begin
                      phase_next = PH_OCR; byte_counter_next = '0; ocr_word_next = '0;
                      out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
                    end else begin
                      do_fin = 1'b1; fin_st = (card_type_bits != 0) ? ST_OK : ST_UNUSABLE;
                    end
            PH_A41V1: begin
              card_type_bits_next = (resp <= 8'd1) ? 4'd2 : 4'd1;
              do_issue = 1'b1; iss = PH_LOOP;
            end
            PH_LOOP: begin do_issue = 1'b1; iss = (resp != 0) ? PH_LOOP : PH_C16; end
            PH_C16: begin
              if (resp != 0) card_type_bits_next = '0;
              do_fin = 1'b1;
              fin_st = (resp == 0 && card_type_bits != 0) ? ST_OK : ST_UNUSABLE;
            end
            PH_C17, PH_C18:
              if (resp == 0) begin
                phase_next = PH_RTOK;
                out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
              end else begin do_fin = 1'b1; fin_st = ST_REJECTED; end
            PH_C12: begin do_fin = 1'b1; fin_st = request_status; end
            PH_C24, PH_C25:
              if (resp == 0) begin
                phase_next = PH_WPOLL;
                out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
              end else begin do_fin = 1'b1; fin_st = ST_REJECTED; end
            default: begin do_issue = 1'b1; iss = PH_C25; end
          endcase
        end
      end else begin
        case (phase)
          PH_DUMMY:
            if (byte_counter < 10'(DummyBytes)) begin
              byte_counter_next = byte_counter + 10'd1;
              out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
            end else begin do_issue = 1'b1; iss = PH_C0; end
          PH_R7, PH_OCR: begin
            ocr_word_next = ocr_sh;
            byte_counter_next = byte_counter + 10'd1;
            if (byte_counter_next < 10'd4) begin
              out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
            end else if (phase == PH_R7) begin
              if (ocr_sh[15:0] == 16'h01AA) begin do_issue = 1'b1; iss = PH_A41V2; end
              else begin
                do_fin = 1'b1; fin_st = (card_type_bits != 0) ? ST_OK : ST_UNUSABLE;
              end
            end else begin
              card_type_bits_next = ocr_sh[30] ? 4'hC : 4'h4;
              do_fin = 1'b1;
            end
          end
          PH_RTOK:
            if (b == IDLE_BYTE) begin
              out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
            end else if (b == TOK_START) begin
              phase_next = PH_RDAT; byte_counter_next = '0;
              out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
            end else if (fcmd == 6'd17) begin
              do_fin = 1'b1; fin_st = ST_TOKEN;
            end else begin
              request_status_next = ST_TOKEN; do_issue = 1'b1; iss = PH_C12;
            end
          PH_RDAT: begin
            out_next.read_byte = b;
            out_next.read_valid = 1'b1;
            byte_counter_next = byte_counter + 10'd1;
            if (byte_counter == LastByte) begin
              phase_next = PH_RCRC; byte_counter_next = '0;
            end
            out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
          end
          PH_RCRC:
            if (byte_counter == '0) begin
              byte_counter_next = 10'd1;
              out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
            end else begin
              blocks_counted_next = blocks_counted + 1'b1;
              blocks_remaining_next = blocks_remaining - 1'b1;
              if (fcmd == 6'd17) do_fin = 1'b1;
              else if (blocks_remaining_next != '0) begin
                phase_next = PH_RTOK;
                out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
              end else begin do_issue = 1'b1; iss = PH_C12; end
            end
          PH_WPOLL: begin
            out_next.send_valid = 1'b1;
            if (b != IDLE_BYTE) out_next.send_byte = IDLE_BYTE;
            else begin
              out_next.send_byte = (fcmd == 6'd24) ? TOK_START : TOK_MULTI;
              phase_next = PH_WDAT; byte_counter_next = '0;
              out_next.want_write_byte = 1'b1;
            end
          end
          PH_WDAT: begin
            out_next.send_byte = d.write_byte; out_next.send_valid = 1'b1;
            byte_counter_next = byte_counter + 10'd1;
            if (byte_counter < LastByte) out_next.want_write_byte = 1'b1;
            else begin phase_next = PH_WCRC; byte_counter_next = '0; end
          end
          PH_WCRC: begin
            out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
            byte_counter_next = byte_counter + 10'd1;
            if (byte_counter >= 10'd2) phase_next = PH_WSTAT;
          end
          PH_WSTAT: begin
            blocks_counted_next = blocks_counted + 1'b1;
            blocks_remaining_next = blocks_remaining - 1'b1;
            if (fcmd == 6'd24) do_fin = 1'b1;
            else begin
              phase_next = (blocks_remaining_next != '0) ? PH_WPOLL : PH_SPOLL;
              out_next.send_byte = IDLE_BYTE; out_next.send_valid = 1'b1;
            end
          end
          PH_SPOLL: begin
            out_next.send_valid = 1'b1;
            if (b == IDLE_BYTE) begin phase_next = PH_SSENT; out_next.send_byte = TOK_STOP; end
            else out_next.send_byte = IDLE_BYTE;
          end
          default: do_fin = 1'b1;
        endcase
      end
    end

    if (do_issue) begin
      phase_next = iss;
      ci = cmd_of(iss, card_type_bits_next, card_address_next, blocks_remaining_next);
      if (ci[38]) begin
        app_command_pending_next = {1'b0, ci[37:32]};
        command_frame_next = build_frame(6'd55, '0);
      end else begin
        app_command_pending_next = '0;
        command_frame_next = build_frame(ci[37:32], ci[31:0]);
      end
      frame_position_next = '0;
      out_next.send_byte = command_frame_next[47:40];
      out_next.send_valid = 1'b1;
    end
    if (do_fin) begin
      if (phase == PH_OCR) fin_st = ST_OK;
      request_status_next = fin_st;
      phase_next = PH_IDLE;
      out_next.finished = 1'b1;
      out_next.send_valid = 1'b0;
      out_next.send_byte = '0;
    end
    out_next.chip_select = (phase_next != PH_IDLE) && (phase_next != PH_DUMMY);
    out_next.status = request_status_next;
    out_next.blocks_done = 16'(blocks_counted_next);
    out_next.card_kind = card_type_bits_next;
    out_next.busy_res = phase_next != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_counter <= '0;
      command_frame <= '0;
      frame_position <= '0;
      card_type_bits <= '0;
      blocks_remaining <= '0;
      blocks_counted <= '0;
      card_address <= '0;
      app_command_pending <= '0;
      ocr_word <= '0;
      request_status <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        byte_counter <= byte_counter_next;
        command_frame <= command_frame_next;
        frame_position <= frame_position_next;
        card_type_bits <= card_type_bits_next;
        blocks_remaining <= blocks_remaining_next;
        blocks_counted <= blocks_counted_next;
        card_address <= card_address_next;
        app_command_pending <= app_command_pending_next;
        ocr_word <= ocr_word_next;
        request_status <= request_status_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_reg <= out_next;
  end

  `SDS_ASSERT_IMP(a_fin_idle, clk, rst, out_valid && out_reg.finished, !out_reg.busy_res)
  `SDS_ASSERT_IMP(a_fin_quiet, clk, rst, out_valid && out_reg.finished, !out_reg.send_valid)
  `SDS_ASSERT_NEXT(a_hold, clk, rst, out_valid && !res.ready, out_valid && $stable(out_reg))
endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the SD card SPI host sequencer. A card-side driver answers
// every exchange using the expected phase of the host, so that init, reads
// and writes get deep. A tracker predicts each result and compares the
// received results in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import sds_pkg::*;

  typedef enum int {
    PH_IDLE, PH_C0, PH_C8, PH_A41V2, PH_C58, PH_A41V1, PH_LOOP, PH_C16, PH_C17,
    PH_C18, PH_C12, PH_C24, PH_A23, PH_C25, PH_DUMMY, PH_R7, PH_OCR, PH_RTOK,
    PH_RDAT, PH_RCRC, PH_WPOLL, PH_WDAT, PH_WCRC, PH_WSTAT, PH_SPOLL, PH_SSENT
  } host_phase_e;

  class sd_host_tracker;
    host_phase_e phase;
    int unsigned count;
    logic [47:0] frame;
    int unsigned pos;
    logic [3:0]  kind;
    logic [15:0] remaining;
    logic [15:0] counted;
    logic [31:0] addr;
    logic [6:0]  acmd;
    logic [31:0] ocr;
    logic [2:0]  stat;
    res_t        nx;
    res_t        pending[$];
    int          errors;

    function new();
      phase = PH_IDLE;
      count = 0;
      frame = '0;
      pos = 0;
      kind = '0;
      remaining = '0;
      counted = '0;
      addr = '0;
      acmd = '0;
      ocr = '0;
      stat = ST_OK;
      errors = 0;
    endfunction

    function void emit(logic [7:0] b);
      nx.send_byte = b;
      nx.send_valid = 1'b1;
    endfunction

    function void finish(logic [2:0] st);
      stat = st;
      phase = PH_IDLE;
      nx.finished = 1'b1;
      nx.send_valid = 1'b0;
      nx.send_byte = '0;
    endfunction

    function void finish_init();
      finish(kind != 0 ? ST_OK : ST_UNUSABLE);
    endfunction

    function logic [47:0] build(logic [5:0] idx, logic [31:0] arg);
      logic [7:0] crc;
      crc = idx == 0 ? 8'h95 : (idx == 8 ? 8'h87 : 8'h01);
      return {2'b01, idx, arg, crc};
    endfunction

    function bit cmd_of(host_phase_e ph, output logic [5:0] idx, output logic [31:0] arg);
      arg = '0;
      case (ph)
        PH_C0: begin idx = 0; return 0; end
        PH_C8: begin idx = 8; arg = 32'h1AA; return 0; end
        PH_A41V2: begin idx = 41; arg = 32'h4000_0000; return 1; end
        PH_C58: begin idx = 58; return 0; end
        PH_A41V1: begin idx = 41; return 1; end
        PH_LOOP: begin
          if (kind[0]) begin idx = 1; return 0; end
          idx = 41;
          return 1;
        end
        PH_C16: begin idx = 16; arg = BlockBytes; return 0; end
        PH_C17: begin idx = 17; arg = addr; return 0; end
        PH_C18: begin idx = 18; arg = addr; return 0; end
        PH_C12: begin idx = 12; return 0; end
        PH_C24: begin idx = 24; arg = addr; return 0; end
        PH_A23: begin idx = 23; arg = {16'h0, remaining}; return 1; end
        default: begin idx = 25; arg = addr; return 0; end
      endcase
    endfunction

    function void issue(host_phase_e ph);
      logic [5:0]  idx;
      logic [31:0] arg;
      phase = ph;
      if (cmd_of(ph, idx, arg)) begin
        acmd = {1'b0, idx};
        frame = build(6'd55, '0);
      end else begin
        acmd = '0;
        frame = build(idx, arg);
      end
      pos = 0;
      emit(frame[47:40]);
    endfunction

    function void on_response(logic [7:0] r);
      case (phase)
        PH_C0: if (r != 1) finish(ST_RESET_FAIL); else issue(PH_C8);
        PH_C8: begin
          if (r == 1) begin
            phase = PH_R7; count = 0; ocr = '0; emit(IDLE_BYTE);
          end else issue(PH_A41V1);
        end
        PH_A41V2: if (r != 0) issue(PH_A41V2); else issue(PH_C58);
        PH_C58: begin
          if (r == 0) begin
            phase = PH_OCR; count = 0; ocr = '0; emit(IDLE_BYTE);
          end else finish_init();
        end
        PH_A41V1: begin
          kind = r <= 1 ? 4'd2 : 4'd1;
          issue(PH_LOOP);
        end
        PH_LOOP: if (r != 0) issue(PH_LOOP); else issue(PH_C16);
        PH_C16: begin
          if (r != 0) kind = '0;
          finish_init();
        end
        PH_C17, PH_C18: begin
          if (r == 0) begin phase = PH_RTOK; emit(IDLE_BYTE); end
          else finish(ST_REJECTED);
        end
        PH_C12: finish(stat);
        PH_C24, PH_C25: begin
          if (r == 0) begin phase = PH_WPOLL; emit(IDLE_BYTE); end
          else finish(ST_REJECTED);
        end
        default: issue(PH_C25);
      endcase
    endfunction

    function void command_step(logic [7:0] b);
      logic [5:0]  idx;
      logic [31:0] arg;
      if (pos < 5) begin
        pos++;
        emit(8'(frame >> (8 * (5 - pos))));
      end else if (pos == 5) begin
        pos = 6;
        emit(IDLE_BYTE);
      end else if (b[7]) begin
        emit(IDLE_BYTE);
      end else if (acmd != 0) begin
        if (b > 1) begin
          acmd = '0;
          on_response(b);
        end else begin
          void'(cmd_of(phase, idx, arg));
          acmd = '0;
          frame = build(idx, arg);
          pos = 0;
          emit(frame[47:40]);
        end
      end else begin
        on_response(b);
      end
    endfunction

    function void data_step(logic [7:0] b, logic [7:0] wb);
      case (phase)
        PH_DUMMY: begin
          if (count < DummyBytes) begin count++; emit(IDLE_BYTE); end
          else issue(PH_C0);
        end
        PH_R7, PH_OCR: begin
          ocr = {ocr[23:0], b};
          count++;
          if (count < 4) emit(IDLE_BYTE);
          else if (phase == PH_R7) begin
            if (ocr[15:0] == 16'h01AA) issue(PH_A41V2); else finish_init();
          end else begin
            kind = ocr[30] ? 4'hC : 4'h4;
            finish_init();
          end
        end
        PH_RTOK: begin
          if (b == IDLE_BYTE) emit(IDLE_BYTE);
          else if (b == TOK_START) begin
            phase = PH_RDAT; count = 0; emit(IDLE_BYTE);
          end else if (frame[45:40] == 17) finish(ST_TOKEN);
          else begin
            stat = ST_TOKEN;
            issue(PH_C12);
          end
        end
        PH_RDAT: begin
          nx.read_byte = b;
          nx.read_valid = 1'b1;
          count++;
          if (count >= BlockBytes) begin phase = PH_RCRC; count = 0; end
          emit(IDLE_BYTE);
        end
        PH_RCRC: begin
          if (count == 0) begin
            count = 1;
            emit(IDLE_BYTE);
          end else begin
            counted++;
            remaining--;
            if (frame[45:40] == 17) finish(ST_OK);
            else if (remaining != 0) begin phase = PH_RTOK; emit(IDLE_BYTE); end
            else issue(PH_C12);
          end
        end
        PH_WPOLL: begin
          if (b != IDLE_BYTE) emit(IDLE_BYTE);
          else begin
            emit(frame[45:40] == 24 ? TOK_START : TOK_MULTI);
            phase = PH_WDAT;
            count = 0;
            nx.want_write_byte = 1'b1;
          end
        end
        PH_WDAT: begin
          emit(wb);
          count++;
          if (count < BlockBytes) nx.want_write_byte = 1'b1;
          else begin phase = PH_WCRC; count = 0; end
        end
        PH_WCRC: begin
          emit(IDLE_BYTE);
          count++;
          if (count >= 3) phase = PH_WSTAT;
        end
        PH_WSTAT: begin
          counted++;
          remaining--;
          if (frame[45:40] == 24) finish(ST_OK);
          else begin
            phase = remaining != 0 ? PH_WPOLL : PH_SPOLL;
            emit(IDLE_BYTE);
          end
        end
        PH_SPOLL: begin
          if (b == IDLE_BYTE) begin phase = PH_SSENT; emit(TOK_STOP); end
          else emit(IDLE_BYTE);
        end
        default: finish(ST_OK);
      endcase
    endfunction

    function void note_request(req_t r);
      nx = '0;
      if (r.operation != OP_XFER) begin
        if (phase == PH_IDLE) begin
          stat = ST_OK;
          counted = '0;
          if (r.operation == OP_INIT) begin
            kind = '0;
            remaining = '0;
            phase = PH_DUMMY;
            count = 1;
            emit(IDLE_BYTE);
          end else begin
            remaining = r.block_count;
            addr = kind[3] ? r.sector_address : r.sector_address << 9;
            if (r.block_count == 0) finish(ST_OK);
            else if (r.operation == OP_READ) issue(r.block_count == 1 ? PH_C17 : PH_C18);
            else if (r.block_count == 1) issue(PH_C24);
            else issue(kind[2:1] != 0 ? PH_A23 : PH_C25);
          end
        end
      end else if (phase != PH_IDLE) begin
        if (phase <= PH_C25) command_step(r.card_byte);
        else data_step(r.card_byte, r.write_byte);
      end
      nx.chip_select = phase != PH_IDLE && phase != PH_DUMMY;
      nx.status = stat;
      nx.blocks_done = counted;
      nx.card_kind = kind;
      nx.busy_res = phase != PH_IDLE;
      pending.push_back(nx);
    endfunction

    function void compare(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $error("Result received with no transaction outstanding.");
        errors++;
        return;
      end
      e = pending.pop_front();
      compare("send_byte", e.send_byte, got.send_byte);
      compare("send_valid", e.send_valid, got.send_valid);
      compare("chip_select", e.chip_select, got.chip_select);
      compare("read_byte", e.read_byte, got.read_byte);
      compare("read_valid", e.read_valid, got.read_valid);
      compare("want_write_byte", e.want_write_byte, got.want_write_byte);
      compare("finished", e.finished, got.finished);
      compare("status", e.status, got.status);
      compare("blocks_done", e.blocks_done, got.blocks_done);
      compare("card_kind", e.card_kind, got.card_kind);
      compare("busy_res", e.busy_res, got.busy_res);
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   items;
  int   idle_mode;
  bit   reject_cmd;
  sd_host_tracker tracker;

  sds_if #(.payload_t(req_t)) req ();
  sds_if #(.payload_t(res_t)) res ();

  sd_spi_host_sequencer uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) tracker.check_result(res.data);
    res.ready <= !((idle_mode == 2 && $urandom_range(99) < 64) ||
                   (idle_mode == 3 && $urandom_range(99) < 9));
  end

  function automatic logic [7:0] card_answer();
    int p;
    p = $urandom_range(99);
    case (tracker.phase)
      PH_R7: return tracker.count == 2 ? (p < 85 ? 8'h01 : 8'($urandom))
                  : tracker.count == 3 ? (p < 85 ? 8'hAA : 8'($urandom)) : 8'($urandom);
      PH_RTOK: return p < 40 ? IDLE_BYTE : (p < 85 ? TOK_START : 8'($urandom));
      PH_WPOLL, PH_SPOLL: return p < 60 ? IDLE_BYTE : 8'($urandom);
      default: ;
    endcase
    if (tracker.phase > PH_C25 || tracker.pos < 6) return 8'($urandom);
    if (p < 20) return p < 10 ? IDLE_BYTE : 8'($urandom_range(128, 255));
    p = $urandom_range(99);
    if (tracker.acmd != 0) return p < 75 ? 8'h01 : (p < 85 ? 8'h00 : 8'($urandom_range(2, 127)));
    case (tracker.phase)
      PH_C0: return p < 90 ? 8'h01 : 8'($urandom_range(127));
      PH_C8: return p < 50 ? 8'h01 : 8'h05;
      PH_A41V1: return p < 40 ? 8'h01 : (p < 70 ? 8'h00 : 8'h05);
      PH_A41V2, PH_LOOP: return p < 60 ? 8'h00 : 8'h01;
      PH_C17, PH_C18, PH_C24, PH_C25: begin
        if (reject_cmd) return 8'h05;
        return p < 88 ? 8'h00 : 8'($urandom_range(1, 127));
      end
      default: return p < 85 ? 8'h00 : 8'($urandom_range(127));
    endcase
  endfunction

  task automatic put_item(req_t r);
    idle_mode = (items / 50) % 4;
    while ((idle_mode == 1 && $urandom_range(99) < 64) ||
           (idle_mode == 3 && $urandom_range(99) < 9)) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.data <= r;
    req.valid <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    tracker.note_request(r);
    items++;
  endtask

  task automatic run_request(logic [1:0] op, logic [31:0] sector, logic [15:0] blocks);
    req_t r;
    r = {op, sector, blocks, 8'($urandom), 8'($urandom)};
    put_item(r);
    while (tracker.phase != PH_IDLE) begin
      if ($urandom_range(199) == 0)
        r = {2'($urandom_range(2)), 32'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)};
      else
        r = {OP_XFER, 32'($urandom), 16'($urandom), card_answer(), 8'($urandom)};
      put_item(r);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int left;
    logic [15:0] blocks;
    tracker = new();
    cycles = 0;
    items = 0;
    idle_mode = 0;
    reject_cmd = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    res.ready = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    put_item({OP_XFER, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF});
    run_request(OP_READ, 32'h0, 16'h0);
    run_request(OP_WRITE, 32'hFFFF_FFFF, 16'h0);
    reject_cmd = 1;
    run_request(OP_READ, 32'h5A5A_5A5A, 16'hFFFF);
    run_request(OP_WRITE, 32'hFFFF_FFFF, 16'hFFFF);
    reject_cmd = 0;
    run_request(OP_INIT, 32'h0, 16'h1);
    drain();

    while (items < 1150) begin
      left = 1150 - items;
      reject_cmd = $urandom_range(9) == 0;
      if (left > 1000) blocks = 16'($urandom_range(2));
      else if (left > 450) blocks = 16'($urandom_range(1));
      else blocks = 16'h0;
      if (reject_cmd) blocks = 16'($urandom);
      case ($urandom_range(2))
        0: run_request(OP_INIT, 32'($urandom), blocks);
        1: run_request(OP_READ, 32'($urandom), blocks);
        default: run_request(OP_WRITE, 32'($urandom), blocks);
      endcase
      if ($urandom_range(5) == 0) put_item({OP_XFER, 32'($urandom), 16'($urandom),
                                            8'($urandom), 8'($urandom)});
      if ($urandom_range(3) == 0) drain();
    end
    drain();
    idle_mode = 0;
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
